// ----- rtl/core/nonpreemptive_priority_scheduler_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the priority scheduler
// Shared helpers that wrap clocking and reset around concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define NPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Boolean condition must never be true outside reset.
`define NPS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/nps_pkg.sv -----
// ----------------------------------------------------------------------------
// Priority scheduler package
// Job record layout and time constants shared by the scheduler modules.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int ID_W   = 16;
  localparam int ARR_W  = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W = 8;
  localparam int TIME_W = 24;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // One stored job as it sits in the job memory.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } job_t;

  localparam int JOB_W = $bits(job_t);

endpackage

// ----- rtl/core/nps_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/nps_cmp.sv -----
// ----------------------------------------------------------------------------
// Job selection comparator
// Decides whether a scanned job replaces the current best candidate.
// ----------------------------------------------------------------------------
module nps_cmp import nps_pkg::*; (
  input  job_t              cand_i,
  input  job_t              best_i,
  input  logic              found_i,
  input  logic [TIME_W-1:0] clock_i,
  output logic              win_o
);

  logic cand_ready;
  logic best_ready;
  logic first;

  // A job is ready when it has arrived by the current time.
  assign cand_ready = ({{(TIME_W-ARR_W){1'b0}}, cand_i.arrival} <= clock_i);
  assign best_ready = ({{(TIME_W-ARR_W){1'b0}}, best_i.arrival} <= clock_i);

  // Service order among ready jobs: priority, then arrival, then id.
  always_comb begin
    if (cand_i.prio != best_i.prio) begin
      first = (cand_i.prio > best_i.prio);
    end else if (cand_i.arrival != best_i.arrival) begin
      first = (cand_i.arrival < best_i.arrival);
    end else begin
      first = (cand_i.id < best_i.id);
    end
  end

  // Ready jobs beat waiting ones. Among waiting jobs the earliest arrival
  // wins, since time will jump to it; equal arrivals use service order.
  always_comb begin
    if (!found_i) begin
      win_o = 1'b1;
    end else if (cand_ready != best_ready) begin
      win_o = cand_ready;
    end else if (!cand_ready && (cand_i.arrival != best_i.arrival)) begin
      win_o = (cand_i.arrival < best_i.arrival);
    end else begin
      win_o = first;
    end
  end

endmodule

// ----- rtl/core/nonpreemptive_priority_scheduler.sv -----
// ----------------------------------------------------------------------------
// Non-preemptive priority scheduler
// Loads a job set, then emits the jobs in execution order with their times.
// ----------------------------------------------------------------------------
// Jobs are loaded one request per cycle into a job memory of MAX_JOBS
// entries; requests beyond a full table are dropped. A request with is_last_i
// set starts the schedule and the input stays not ready until the final
// result is taken. Each result takes one scan of the stored jobs through a
// single comparator, one memory entry per cycle; after the scan the scheduler
// advances time, forms the completion, turnaround and waiting times in turn,
// and presents the result until it is taken. Among ready jobs the highest
// priority runs first, ties go to the earlier arrival and then the lower id;
// if nothing is ready, time jumps to the earliest pending arrival. Completion
// time saturates at the 24-bit maximum.
module nonpreemptive_priority_scheduler import nps_pkg::*; #(
  parameter int MAX_JOBS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ID_W-1:0]    job_id_i,
  input  logic [ARR_W-1:0]   arrival_time_i,
  input  logic [BURST_W-1:0] burst_time_i,
  input  logic [PRIO_W-1:0]  job_priority_i,
  input  logic               is_last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ID_W-1:0]    out_id_o,
  output logic [TIME_W-1:0]  completion_time_o,
  output logic [TIME_W-1:0]  turnaround_time_o,
  output logic [TIME_W-1:0]  waiting_time_o,
  output logic               last_result_o
);

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_ALIGN,
    ST_ADD,
    ST_TURN,
    ST_WAIT,
    ST_OUT
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    job_cnt_q, job_cnt_d;
  logic [CNT_W-1:0]    res_cnt_q, res_cnt_d;
  logic [CNT_W-1:0]    iss_cnt_q, iss_cnt_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [MAX_JOBS-1:0] done_q, done_d;
  logic                found_q, found_d;
  logic [TIME_W-1:0]   clock_q, clock_d;
  logic                out_valid_q, out_valid_d;

  logic [IDX_W-1:0]    cmp_idx_q, cmp_idx_d;
  job_t                best_q, best_d;
  logic [IDX_W-1:0]    best_idx_q, best_idx_d;
  logic [TIME_W-1:0]   compl_q, compl_d;
  logic [TIME_W-1:0]   turn_q, turn_d;
  logic [TIME_W-1:0]   wait_q, wait_d;

  logic              in_fire;
  logic              can_store;
  logic              issue;
  logic              consider;
  logic              win;
  logic              last_res;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] best_arr;
  logic [TIME_W-1:0] best_burst;
  job_t              wr_job;
  job_t              cand;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign can_store  = (job_cnt_q < CNT_W'(MAX_JOBS));
  assign issue      = (iss_cnt_q < job_cnt_q);
  assign last_res   = ((res_cnt_q + CNT_W'(1)) == job_cnt_q);
  assign best_arr   = {{(TIME_W-ARR_W){1'b0}}, best_q.arrival};
  assign best_burst = {{(TIME_W-BURST_W){1'b0}}, best_q.burst};
  assign sum        = {1'b0, clock_q} + {{(TIME_W+1-BURST_W){1'b0}}, best_q.burst};

  // Job memory: written while loading, read in order during each scan.
  always_comb begin
    wr_job.id      = job_id_i;
    wr_job.arrival = arrival_time_i;
    wr_job.burst   = burst_time_i;
    wr_job.prio    = job_priority_i;
  end

  nps_ram #(
    .WIDTH(JOB_W),
    .DEPTH(MAX_JOBS),
    .AW   (IDX_W)
  ) u_job_ram (
    .clk_i  (clk_i),
    .we_i   (in_fire && can_store),
    .waddr_i(job_cnt_q[IDX_W-1:0]),
    .wdata_i(wr_job),
    .raddr_i(iss_cnt_q[IDX_W-1:0]),
    .rdata_o(cand)
  );

  // Shared comparator against the running best candidate.
  nps_cmp u_cmp (
    .cand_i (cand),
    .best_i (best_q),
    .found_i(found_q),
    .clock_i(clock_q),
    .win_o  (win)
  );

  assign consider = cmp_vld_q && !done_q[cmp_idx_q];

  // Sequencer: load, scan, advance time, compute the result, hand it off.
  always_comb begin
    state_d     = state_q;
    job_cnt_d   = job_cnt_q;
    res_cnt_d   = res_cnt_q;
    iss_cnt_d   = iss_cnt_q;
    cmp_vld_d   = cmp_vld_q;
    done_d      = done_q;
    found_d     = found_q;
    clock_d     = clock_q;
    out_valid_d = out_valid_q;
    cmp_idx_d   = cmp_idx_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    compl_d     = compl_q;
    turn_d      = turn_q;
    wait_d      = wait_q;

    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (can_store) begin
            job_cnt_d = job_cnt_q + CNT_W'(1);
          end
          if (is_last_i) begin
            clock_d   = '0;
            res_cnt_d = '0;
            iss_cnt_d = '0;
            found_d   = 1'b0;
            cmp_vld_d = 1'b0;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          iss_cnt_d = iss_cnt_q + CNT_W'(1);
        end
        cmp_vld_d = issue;
        cmp_idx_d = iss_cnt_q[IDX_W-1:0];
        if (consider && win) begin
          best_d     = cand;
          best_idx_d = cmp_idx_q;
          found_d    = 1'b1;
        end
        if (!issue && !cmp_vld_q) begin
          state_d = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        // Idle gap: time jumps forward to the chosen job's arrival.
        if (best_arr > clock_q) begin
          clock_d = best_arr;
        end
        state_d = ST_ADD;
      end
      ST_ADD: begin
        compl_d            = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        clock_d            = compl_d;
        done_d[best_idx_q] = 1'b1;
        state_d            = ST_TURN;
      end
      ST_TURN: begin
        turn_d  = compl_q - best_arr;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        wait_d      = (turn_q > best_burst) ? (turn_q - best_burst) : '0;
        out_valid_d = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (last_res) begin
            job_cnt_d = '0;
            done_d    = '0;
            state_d   = ST_LOAD;
          end else begin
            res_cnt_d = res_cnt_q + CNT_W'(1);
            iss_cnt_d = '0;
            found_d   = 1'b0;
            cmp_vld_d = 1'b0;
            state_d   = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Control state and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      job_cnt_q   <= '0;
      res_cnt_q   <= '0;
      iss_cnt_q   <= '0;
      cmp_vld_q   <= 1'b0;
      done_q      <= '0;
      found_q     <= 1'b0;
      clock_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_cnt_q   <= job_cnt_d;
      res_cnt_q   <= res_cnt_d;
      iss_cnt_q   <= iss_cnt_d;
      cmp_vld_q   <= cmp_vld_d;
      done_q      <= done_d;
      found_q     <= found_d;
      clock_q     <= clock_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    compl_q    <= compl_d;
    turn_q     <= turn_d;
    wait_q     <= wait_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_id_o          = best_q.id;
  assign completion_time_o = compl_q;
  assign turnaround_time_o = turn_q;
  assign waiting_time_o    = wait_q;
  assign last_result_o     = last_res;

endmodule

// ----- rtl/core/nps_checker.sv -----
// ----------------------------------------------------------------------------
// Priority scheduler port checker
// Watches the scheduler's ports for ordering and phase violations.
// ----------------------------------------------------------------------------
`include "nonpreemptive_priority_scheduler_defines.svh"

module nps_checker import nps_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               is_last_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [ID_W-1:0]    out_id_o,
  input logic [TIME_W-1:0]  completion_time_o,
  input logic [TIME_W-1:0]  turnaround_time_o,
  input logic [TIME_W-1:0]  waiting_time_o,
  input logic               last_result_o
);

  // A stalled result keeps its contents.
  `NPS_ASSERT(a_out_hold, clk_i, rst_ni,
              (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_id_o)
                && $stable(completion_time_o) && $stable(turnaround_time_o)
                && $stable(waiting_time_o) && $stable(last_result_o)),
              "stalled result changed")

  // Loading and result delivery never overlap.
  `NPS_ASSERT_NEVER(a_phase_excl, clk_i, rst_ni, in_ready_o && out_valid_o,
                    "ready for input while a result is pending")

  // The final job of a set closes the input until the schedule ends.
  `NPS_ASSERT(a_last_closes, clk_i, rst_ni,
              (in_valid_i && in_ready_o && is_last_i) |=> !in_ready_o,
              "input still open after the last job")

  // A job that is not last keeps the input open for the next one.
  `NPS_ASSERT(a_load_open, clk_i, rst_ni,
              (in_valid_i && in_ready_o && !is_last_i) |=> in_ready_o,
              "input closed during loading")

  // Taking the final result ends the schedule.
  `NPS_ASSERT(a_last_ends, clk_i, rst_ni,
              (out_valid_o && out_ready_i && last_result_o) |=> (!out_valid_o && in_ready_o),
              "schedule did not end after the final result")

endmodule

bind nonpreemptive_priority_scheduler nps_checker u_nps_checker (.*);

// ----- sim/tb_nonpreemptive_priority_scheduler.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the non-preemptive priority scheduler
// Loads job sets through the request channel and predicts each schedule in
// the bench. Every result is checked field by field against the oldest
// prediction, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_nonpreemptive_priority_scheduler;
  import nps_pkg::*;

  localparam int MAX_JOBS = 16;

  // One queued request plus how the driver should present it.
  typedef struct {
    job_t        job;
    logic        last;
    int unsigned gap;
    bit          drain;
    bit          tail;
  } job_req_t;

  // One predicted schedule entry.
  typedef struct {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] completion;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              last;
  } sched_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [ID_W-1:0]    job_id = '0;
  logic [ARR_W-1:0]   arrival_time = '0;
  logic [BURST_W-1:0] burst_time = '0;
  logic [PRIO_W-1:0]  job_priority = '0;
  logic               is_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ID_W-1:0]    out_id;
  logic [TIME_W-1:0]  completion_time;
  logic [TIME_W-1:0]  turnaround_time;
  logic [TIME_W-1:0]  waiting_time;
  logic               last_result;

  job_req_t      job_queue[$];
  sched_result_t due_results[$];
  int unsigned   mismatch_count = 0;
  bit            calm_tail = 1'b0;

  // Bench copy of the scheduler state.
  job_t        job_table[MAX_JOBS];
  bit          finished[MAX_JOBS];
  int unsigned loaded = 0;
  int unsigned now_tick = 0;

  nonpreemptive_priority_scheduler #(
    .MAX_JOBS(MAX_JOBS)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .job_id_i         (job_id),
    .arrival_time_i   (arrival_time),
    .burst_time_i     (burst_time),
    .job_priority_i   (job_priority),
    .is_last_i        (is_last),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .out_id_o         (out_id),
    .completion_time_o(completion_time),
    .turnaround_time_o(turnaround_time),
    .waiting_time_o   (waiting_time),
    .last_result_o    (last_result)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  // Job a is served before job b when both are ready.
  function automatic bit outranks(input int unsigned a, input int unsigned b);
    if (job_table[a].prio != job_table[b].prio) return job_table[a].prio > job_table[b].prio;
    if (job_table[a].arrival != job_table[b].arrival)
      return job_table[a].arrival < job_table[b].arrival;
    return job_table[a].id < job_table[b].id;
  endfunction

  // Play out the stored set and queue one prediction per job in run order.
  function automatic void run_priority_order();
    int unsigned   pick;
    int unsigned   earliest;
    int unsigned   finish_tick;
    int unsigned   turn;
    int unsigned   idle_ticks;
    sched_result_t res;
    now_tick = 0;
    for (int unsigned n = 0; n < loaded; n++) begin
      // Jump ahead when nothing pending has arrived yet.
      earliest = TIME_MAX;
      for (int unsigned k = 0; k < loaded; k++) begin
        if (!finished[k] && job_table[k].arrival < earliest) earliest = job_table[k].arrival;
      end
      if (earliest > now_tick) now_tick = earliest;
      // Strict ranking keeps load order between fully equal jobs.
      pick = MAX_JOBS;
      for (int unsigned k = 0; k < loaded; k++) begin
        if (finished[k] || job_table[k].arrival > now_tick) continue;
        if (pick == MAX_JOBS || outranks(k, pick)) pick = k;
      end
      finish_tick = now_tick + job_table[pick].burst;
      if (finish_tick > TIME_MAX) finish_tick = TIME_MAX;
      turn = finish_tick - job_table[pick].arrival;
      idle_ticks = (turn > job_table[pick].burst) ? turn - job_table[pick].burst : 0;
      now_tick = finish_tick;
      finished[pick] = 1'b1;
      res.id = job_table[pick].id;
      res.completion = finish_tick[TIME_W-1:0];
      res.turnaround = turn[TIME_W-1:0];
      res.waiting = idle_ticks[TIME_W-1:0];
      res.last = (n + 1 == loaded);
      due_results.push_back(res);
    end
    loaded = 0;
    finished = '{default: 1'b0};
  endfunction

  // Store an accepted job; a full table drops it, the last flag still counts.
  function automatic void admit_job(input job_req_t req);
    if (loaded < MAX_JOBS) begin
      job_table[loaded] = req.job;
      finished[loaded] = 1'b0;
      loaded++;
    end
    if (req.last) run_priority_order();
  endfunction

  // Request driver: takes queued jobs in order, with gaps and drain pauses.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    bit          present;
    int unsigned hold_cnt;
    bit          primed;
    job_req_t    cur_req;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      calm_tail <= 1'b0;
      hold_cnt = 0;
      primed = 1'b0;
    end else begin
      present = in_valid;
      if (in_valid && in_ready) begin
        admit_job(cur_req);
        present = 1'b0;
      end
      if (!present && job_queue.size() != 0) begin
        if (!primed) begin
          hold_cnt = job_queue[0].gap;
          primed = 1'b1;
        end
        if (hold_cnt != 0) begin
          hold_cnt--;
        end else if (!job_queue[0].drain || due_results.size() == 0) begin
          cur_req = job_queue.pop_front();
          primed = 1'b0;
          present = 1'b1;
          job_id <= cur_req.job.id;
          arrival_time <= cur_req.job.arrival;
          burst_time <= cur_req.job.burst;
          job_priority <= cur_req.job.prio;
          is_last <= cur_req.last;
          calm_tail <= cur_req.tail;
        end
      end
      in_valid <= present;
    end
  end

  // Result monitor: checks accepted results and drives ready with stall bursts.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    int unsigned   stall_left;
    bit            stall_phase;
    bit            rdy;
    sched_result_t exp_res;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left = 0;
      stall_phase = 1'b1;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result id=%0h", out_id));
        end else begin
          exp_res = due_results.pop_front();
          if (out_id !== exp_res.id || completion_time !== exp_res.completion ||
              turnaround_time !== exp_res.turnaround || waiting_time !== exp_res.waiting ||
              last_result !== exp_res.last)
            flag_mismatch($sformatf(
              "got id=%h c=%h t=%h w=%h l=%b, want id=%h c=%h t=%h w=%h l=%b",
              out_id, completion_time, turnaround_time, waiting_time, last_result,
              exp_res.id, exp_res.completion, exp_res.turnaround, exp_res.waiting,
              exp_res.last));
        end
      end
      // Stalls come in phases so that some stretches run without any.
      if ($urandom_range(0, 49) == 0) stall_phase = !stall_phase;
      if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (!calm_tail && stall_phase && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 12);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  task automatic add_request(input logic [ID_W-1:0] id, input logic [ARR_W-1:0] arr,
                             input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio,
                             input logic last, input int unsigned gap, input bit drain,
                             input bit tail);
    job_req_t req;
    req.job.id = id;
    req.job.arrival = arr;
    req.job.burst = burst;
    req.job.prio = prio;
    req.last = last;
    req.gap = gap;
    req.drain = drain;
    req.tail = tail;
    job_queue.push_back(req);
  endtask

  // One random job set; the spread of each field is chosen per set so that
  // some sets crowd into ties and idle jumps while others span full ranges.
  task automatic add_random_set(input int unsigned n, input bit tail);
    int unsigned        arr_mode;
    int unsigned        prio_mode;
    int unsigned        burst_mode;
    int unsigned        id_mode;
    bit                 bursty;
    int unsigned        gap;
    logic [ID_W-1:0]    id;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    arr_mode = $urandom_range(0, 2);
    prio_mode = $urandom_range(0, 1);
    burst_mode = $urandom_range(0, 1);
    id_mode = $urandom_range(0, 1);
    bursty = $urandom_range(0, 2) != 0;
    for (int unsigned i = 0; i < n; i++) begin
      id = id_mode ? 16'($urandom()) : 16'($urandom_range(0, 3));
      case (arr_mode)
        0: arr = 16'($urandom_range(0, 30));
        1: arr = 16'($urandom_range(0, 1000));
        default: arr = 16'($urandom());
      endcase
      burst = burst_mode ? 16'($urandom()) : 16'($urandom_range(0, 20));
      prio = prio_mode ? 8'($urandom()) : 8'($urandom_range(0, 3));
      gap = (!tail && bursty && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
      add_request(id, arr, burst, prio, i == n - 1, gap,
                  i == 0 && $urandom_range(0, 4) == 0, tail);
    end
  endtask

  initial begin : stimulus
    int unsigned random_items;
    int unsigned set_size;
    random_items = 0;

    // Single jobs at the field extremes.
    add_request('0, '0, '0, '0, 1'b1, 0, 1'b0, 1'b0);
    add_request('1, '1, '1, '1, 1'b1, 0, 1'b0, 1'b0);

    // Tie rules, a fully equal pair, an idle start and an idle gap later on.
    // The sender first waits until the previous results are all back.
    add_request(16'd7, 16'd10, 16'd4, 8'd5, 1'b0, 0, 1'b1, 1'b0);
    add_request(16'd3, 16'd10, 16'd2, 8'd5, 1'b0, 0, 1'b0, 1'b0);
    add_request(16'd9, 16'd8, 16'd1, 8'd5, 1'b0, 0, 1'b0, 1'b0);
    add_request(16'd3, 16'd10, 16'd6, 8'd5, 1'b0, 0, 1'b0, 1'b0);
    add_request(16'd1, 16'd40, 16'd3, 8'd200, 1'b1, 0, 1'b0, 1'b0);

    // Full table: the seventeenth job is dropped but still starts the run.
    for (int unsigned i = 0; i < 16; i++)
      add_request(16'(100 + i), '0, 16'(i + 1), 8'((i * 15) % 256), 1'b0, 0, 1'b0, 1'b0);
    add_request(16'hABCD, '0, 16'd5, 8'hFF, 1'b1, 0, 1'b0, 1'b0);

    // Random sets, mostly small, a few filling or past the table size.
    while (random_items < 176) begin
      set_size = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 8);
      add_random_set(set_size, random_items >= 145);
      random_items += set_size;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (job_queue.size() != 0 || in_valid) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard limit well beyond the slowest legal run.
  initial begin : watchdog
    #20000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- nonpreemptive_priority_scheduler.f -----
+incdir+rtl/core
rtl/core/nps_pkg.sv
rtl/core/nps_ram.sv
rtl/core/nps_cmp.sv
rtl/core/nonpreemptive_priority_scheduler.sv
rtl/core/nps_checker.sv
sim/tb_nonpreemptive_priority_scheduler.sv
